// ----- rtl/core/bptg_pkg.sv -----
// Package for the big power-of-ten generator core.
// Holds sizes, the small and large power tables and the sequencer state type.
// No dependencies; imported by big_power_of_ten_generator_core.
`timescale 1ns / 1ps

package bptg_pkg;

    // Sizes of the block store and of the emitted result.
    localparam int MAX_BLOCKS  = 64;
    localparam int EMIT_LIMIT  = 64;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(MAX_BLOCKS);
    localparam int LEN_W       = $clog2(MAX_BLOCKS + 1);
    localparam int EMIT_W      = $clog2(EMIT_LIMIT + 1);
    localparam int IDX_W       = 6;
    localparam int EXP_W       = 9;

    // Large power table geometry.
    localparam int BIG_CNT     = 6;
    localparam int BIG_MAX_LEN = 27;
    localparam int ROW_W       = $clog2(BIG_MAX_LEN);
    localparam int TAB_W       = $clog2(BIG_CNT + 1);
    localparam int POS_W       = $clog2(MAX_BLOCKS + BIG_MAX_LEN);

    // 10^0 .. 10^7, selected by the low three exponent bits.
    localparam logic [WORD_W-1:0] SMALL_POW [8] = '{
        32'd1, 32'd10, 32'd100, 32'd1000,
        32'd10000, 32'd100000, 32'd1000000, 32'd10000000
    };

    // Block counts of 10^8, 10^16, 10^32, 10^64, 10^128 and 10^256.
    localparam logic [ROW_W-1:0] BIG_LEN [BIG_CNT] = '{
        5'd1, 5'd2, 5'd4, 5'd7, 5'd14, 5'd27
    };

    // Blocks of the large powers, least significant first, zero padded.
    localparam logic [WORD_W-1:0] BIG_POW [BIG_CNT][BIG_MAX_LEN] = '{
        '{32'd100000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h6fc10000, 32'h002386f2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h00000000, 32'h85acef81, 32'h2d6d415b, 32'h000004ee, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h00000000, 32'h00000000, 32'hbf6a1f01, 32'h6e38ed64, 32'hdaa797ed,
          32'he93ff9f4, 32'h00184f03, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h2e953e01,
          32'h03df9909, 32'h0f1538fd, 32'h2374e42f, 32'hd3cff5ec, 32'hc404dc08,
          32'hbccdb0da, 32'ha6337f19, 32'he91f2603, 32'h0000024e, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0},
        '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 32'h00000000, 32'h982e7c01, 32'hbed3875b,
          32'hd8d99f72, 32'h12152f87, 32'h6bde50c6, 32'hcf4a6e70, 32'hd595d80f,
          32'h26b2716e, 32'hadc666b0, 32'h1d153624, 32'h3c42d35a, 32'h63ff540e,
          32'hcc5573c0, 32'h65f9ef17, 32'h55bc28f2, 32'h80dcc7f7, 32'hf46eeddc,
          32'h5fdcefce, 32'h000553f7}
    };

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_NEXT   = 8'b0000_0010,
        S_ROW    = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_CARRY  = 8'b0001_0000,
        S_FINISH = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

endpackage

// ----- rtl/core/bptg_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for the two block stores of the power generator core.
`timescale 1ns / 1ps

module bptg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/big_power_of_ten_generator_core.sv -----
// Big power-of-ten generator: emits 10^exponent as 32-bit blocks, LSB block first.
// The result is presented one block per cycle, with no stall, once all multiplies are
// done.
// One transaction at a time on one shared 32x32 multiplier; busy falls in the cycle
// before the last block is presented, and the next transaction may start then.
// Reset clears control state; block stores are undefined. Needs bptg_pkg, bptg_ram.
`timescale 1ns / 1ps

module big_power_of_ten_generator_core
    import bptg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [EXP_W-1:0]      exponent,
    output logic                  result_valid,
    output logic [WORD_W-1:0]     block_value,
    output logic [IDX_W-1:0]      block_index,
    output logic                  last_block
);

    // Sequencer state.
    state_t              state_reg, state_next;
    logic [5:0]          exp_hi_reg, exp_hi_next;
    logic [TAB_W-1:0]    tab_reg, tab_next;
    logic                sel_reg, sel_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]    total_reg, total_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [WORD_W-1:0]   mult_reg, mult_next;
    logic [WORD_W-1:0]   carry_reg, carry_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic [EMIT_W-1:0]   k_reg, k_next;
    logic [EMIT_W-1:0]   emit_n_reg, emit_n_next;

    // Multiply pipeline.
    logic                s1_valid_reg, s1_valid_next;
    logic [POS_W-1:0]    s1_pos_reg, s1_pos_next;
    logic                s1_first_reg, s1_first_next;
    logic                s2_valid_reg;
    logic [POS_W-1:0]    s2_pos_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0]   part_reg;

    // Emit pipeline and output registers.
    logic                e1_valid_reg, e1_valid_next;
    logic [IDX_W-1:0]    e1_index_reg, e1_index_next;
    logic                e1_last_reg, e1_last_next;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_value_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic                out_last_reg;

    // RAM ports.
    logic                we_a, we_b;
    logic [ADDR_W-1:0]   waddr_a, waddr_b, raddr_a, raddr_b;
    logic [WORD_W-1:0]   wdata_a, wdata_b, q_a, q_b;

    // Role views of the two stores.
    logic                cur_we;
    logic [WORD_W-1:0]   cur_wdata;
    logic [ADDR_W-1:0]   cur_raddr;
    logic                part_we;
    logic [ADDR_W-1:0]   part_waddr, part_raddr;
    logic [WORD_W-1:0]   part_wdata;
    logic [WORD_W-1:0]   cur_q, part_q;

    logic                accept;
    logic [POS_W-1:0]    issue_pos;
    logic [POS_W-1:0]    carry_pos;
    logic [POS_W-1:0]    total_pos;
    logic [POS_W-1:0]    len_sum;
    logic [2*WORD_W-1:0] acc_sum;
    int                  n_full;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign total_pos = POS_W'(total_reg);
    assign issue_pos = POS_W'(row_reg) + POS_W'(col_reg);
    assign carry_pos = POS_W'(row_reg) + POS_W'(cur_len_reg);
    assign len_sum   = POS_W'(cur_len_reg) + POS_W'(BIG_LEN[tab_reg]);
    assign acc_sum   = prod_reg + {{WORD_W{1'b0}}, part_reg} + {{WORD_W{1'b0}}, carry_reg};

    // The running value lives in one store and the product is built in the other.
    assign cur_q  = sel_reg ? q_b : q_a;
    assign part_q = sel_reg ? q_a : q_b;

    assign cur_we     = accept;
    assign cur_wdata  = SMALL_POW[exponent[2:0]];
    assign cur_raddr  = (state_reg == S_EMIT) ? k_reg[ADDR_W-1:0] : col_reg;
    assign part_raddr = issue_pos[ADDR_W-1:0];

    // Partial store writes: accumulate stage, or the final carry of a row.
    always_comb
    begin
        part_we    = 1'b0;
        part_waddr = s2_pos_reg[ADDR_W-1:0];
        part_wdata = acc_sum[WORD_W-1:0];
        if (s2_valid_reg)
        begin
            part_we = (s2_pos_reg < total_pos);
        end
        else if (state_reg == S_CARRY)
        begin
            part_we    = (carry_pos < total_pos);
            part_waddr = carry_pos[ADDR_W-1:0];
            part_wdata = carry_reg;
        end
    end

    // Map roles onto the physical stores.
    assign we_a    = sel_reg ? part_we : cur_we;
    assign waddr_a = sel_reg ? part_waddr : {ADDR_W{1'b0}};
    assign wdata_a = sel_reg ? part_wdata : cur_wdata;
    assign raddr_a = sel_reg ? part_raddr : cur_raddr;
    assign we_b    = sel_reg ? cur_we : part_we;
    assign waddr_b = sel_reg ? {ADDR_W{1'b0}} : part_waddr;
    assign wdata_b = sel_reg ? cur_wdata : part_wdata;
    assign raddr_b = sel_reg ? cur_raddr : part_raddr;

    bptg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .raddr (raddr_a),
        .rdata (q_a)
    );

    bptg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata_b),
        .raddr (raddr_b),
        .rdata (q_b)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        exp_hi_next   = exp_hi_reg;
        tab_next      = tab_reg;
        sel_next      = sel_reg;
        cur_len_next  = cur_len_reg;
        total_next    = total_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        mult_next     = mult_reg;
        carry_next    = carry_reg;
        top_next      = top_reg;
        k_next        = k_reg;
        emit_n_next   = emit_n_reg;
        s1_valid_next = 1'b0;
        s1_pos_next   = issue_pos;
        s1_first_next = (row_reg == '0);
        e1_valid_next = 1'b0;
        e1_index_next = k_reg[IDX_W-1:0];
        e1_last_next  = (k_reg == emit_n_reg - EMIT_W'(1));
        n_full        = (int'(cur_len_reg) > EMIT_LIMIT) ? EMIT_LIMIT : int'(cur_len_reg);

        // The accumulate stage tracks the carry and the top block of the product.
        if (s2_valid_reg)
        begin
            carry_next = acc_sum[2*WORD_W-1:WORD_W];
            if (s2_pos_reg == total_pos - POS_W'(1))
            begin
                top_next = acc_sum[WORD_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    exp_hi_next  = exponent[EXP_W-1:3];
                    tab_next     = '0;
                    cur_len_next = LEN_W'(1);
                    state_next   = S_NEXT;
                end
            end
            // Look for the next set exponent bit, or start emitting.
            S_NEXT:
            begin
                if (tab_reg == TAB_W'(BIG_CNT))
                begin
                    k_next      = '0;
                    emit_n_next = EMIT_W'(n_full);
                    state_next  = S_EMIT;
                end
                else if (exp_hi_reg[tab_reg])
                begin
                    total_next = (len_sum > POS_W'(MAX_BLOCKS)) ?
                                 LEN_W'(MAX_BLOCKS) : LEN_W'(len_sum);
                    row_next   = '0;
                    col_next   = '0;
                    mult_next  = BIG_POW[tab_reg][0];
                    carry_next = '0;
                    state_next = S_ROW;
                end
                else
                begin
                    tab_next = tab_reg + TAB_W'(1);
                end
            end
            // Issue one block product per cycle along the running value.
            S_ROW:
            begin
                s1_valid_next = 1'b1;
                if (LEN_W'(col_reg) == cur_len_reg - LEN_W'(1))
                begin
                    col_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = S_CARRY;
                end
            end
            // Store the row's carry, then move to the next table block or finish the multiply.
            S_CARRY:
            begin
                if (carry_pos == total_pos - POS_W'(1))
                begin
                    top_next = carry_reg;
                end
                carry_next = '0;
                if (row_reg == BIG_LEN[tab_reg] - ROW_W'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    mult_next  = BIG_POW[tab_reg][row_reg + ROW_W'(1)];
                    state_next = S_ROW;
                end
            end
            // Trim a zero top block, swap the store roles and go on to the next exponent bit.
            S_FINISH:
            begin
                cur_len_next = total_reg - LEN_W'(top_reg == '0);
                sel_next     = ~sel_reg;
                tab_next     = tab_reg + TAB_W'(1);
                state_next   = S_NEXT;
            end
            // Read out one block per cycle.
            S_EMIT:
            begin
                e1_valid_next = 1'b1;
                k_next        = k_reg + EMIT_W'(1);
                if (k_reg == emit_n_reg - EMIT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tab_reg       <= '0;
            sel_reg       <= 1'b0;
            cur_len_reg   <= '0;
            total_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            emit_n_reg    <= '0;
            carry_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tab_reg       <= tab_next;
            sel_reg       <= sel_next;
            cur_len_reg   <= cur_len_next;
            total_reg     <= total_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            emit_n_reg    <= emit_n_next;
            carry_reg     <= carry_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            e1_valid_reg  <= e1_valid_next;
            out_valid_reg <= e1_valid_reg;
        end
    end

    // Payload registers: multiplier stage, emit stage and outputs.
    always_ff @(posedge clk)
    begin
        exp_hi_reg    <= exp_hi_next;
        mult_reg      <= mult_next;
        top_reg       <= top_next;
        s1_pos_reg    <= s1_pos_next;
        s1_first_reg  <= s1_first_next;
        s2_pos_reg    <= s1_pos_reg;
        prod_reg      <= cur_q * mult_reg;
        part_reg      <= s1_first_reg ? '0 : part_q;
        e1_index_reg  <= e1_index_next;
        e1_last_reg   <= e1_last_next;
        out_value_reg <= cur_q;
        out_index_reg <= e1_index_reg;
        out_last_reg  <= e1_last_reg;
    end

    assign result_valid = out_valid_reg;
    assign block_value  = out_value_reg;
    assign block_index  = out_index_reg;
    assign last_block   = out_last_reg;

endmodule
